// ----- rtl/wfad_pkg.sv -----
// Package with action codes, register indexes, constants and reset values of the drive controller.
`default_nettype none

package wfad_pkg;

  localparam int unsigned EchoBitsDef = 14;
  localparam int unsigned HoldBitsDef = 12;

  localparam int unsigned GainBits  = 10;
  localparam int unsigned SpeedBits = 8;
  localparam int unsigned DriveBits = 9;
  localparam int unsigned CfgIdxBits = 3;

  localparam int unsigned EchoTimeoutUs = 15000;
  localparam int unsigned BrakeMs       = 40;
  localparam int unsigned FullDrive     = 255;
  localparam int unsigned EscapeInner   = 100;

  localparam logic [2:0] ACT_READY  = 3'd0;
  localparam logic [2:0] ACT_CRUISE = 3'd1;
  localparam logic [2:0] ACT_SPIN   = 3'd2;
  localparam logic [2:0] ACT_BRAKE  = 3'd3;
  localparam logic [2:0] ACT_ESCAPE = 3'd4;
  localparam logic [2:0] ACT_CENTER = 3'd5;

  localparam logic [CfgIdxBits-1:0] CFG_FRONT_LIMIT = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SIDE_LIMIT  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_CRUISE      = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_BASE        = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_GAIN        = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_DIFF_LIMIT  = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_TURN        = 3'd6;
  localparam logic [CfgIdxBits-1:0] CFG_ESCAPE      = 3'd7;

  localparam int unsigned RstFrontLimit = 411;
  localparam int unsigned RstSideLimit  = 117;
  localparam int unsigned RstCruise     = 240;
  localparam int unsigned RstBase       = 180;
  localparam int unsigned RstGain       = 87;
  localparam int unsigned RstDiffLimit  = 100;
  localparam int unsigned RstTurn       = 380;
  localparam int unsigned RstEscape     = 150;

endpackage

`default_nettype wire

// ----- rtl/wfad_if.sv -----
// Valid/ready channel interfaces for measurement items and drive results.
`default_nettype none

interface wfad_in_if #(
  parameter int unsigned ECHO_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ECHO_BITS-1:0] echo_front_us;
  logic [ECHO_BITS-1:0] echo_left_us;
  logic [ECHO_BITS-1:0] echo_right_us;

  modport source (output valid, func, echo_front_us, echo_left_us, echo_right_us,
                  input ready);
  modport sink (input valid, func, echo_front_us, echo_left_us, echo_right_us,
                output ready);
endinterface

interface wfad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_fwd_duty;
  logic [7:0] left_rev_duty;
  logic [7:0] right_fwd_duty;
  logic [7:0] right_rev_duty;
  logic [2:0] action;
  logic       accepted;

  modport source (output valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                  right_rev_duty, action, accepted, input ready);
  modport sink (input valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                right_rev_duty, action, accepted, output ready);
endinterface

`default_nettype wire

// ----- rtl/wall_follow_avoid_drive.sv -----
// Wall-following drive controller with obstacle avoidance for a differential robot.
// An item transferred in is held in the input register, then loaded into the result register
// once that register is empty or its result is taken; its result transfers from there.
// Throughput: one item per cycle; the input stalls only while the input register holds an
// item and the result register holds a result that is not taken.
// Reset: asynchronous, active low; action ready, no hold, both drives zero, registers at defaults.
`default_nettype none

module wall_follow_avoid_drive
  import wfad_pkg::*;
#(
  parameter int unsigned ECHO_BITS = EchoBitsDef,
  parameter int unsigned HOLD_BITS = HoldBitsDef,
  localparam int unsigned CfgDataBits =
    (ECHO_BITS > HOLD_BITS) ? ((ECHO_BITS > GainBits) ? ECHO_BITS : GainBits)
                            : ((HOLD_BITS > GainBits) ? HOLD_BITS : GainBits)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  wfad_in_if.sink                     in_i,
  wfad_out_if.source                  out_o
);

  localparam int unsigned ProdBits = ECHO_BITS + GainBits;
  localparam int unsigned QBits    = ProdBits - 8;
  localparam int unsigned SumBits  = DriveBits + 1;

  // Configuration registers.
  logic [ECHO_BITS-1:0] front_limit_q, side_limit_q;
  logic [SpeedBits-1:0] cruise_q, base_q, diff_limit_q;
  logic [GainBits-1:0]  gain_q;
  logic [HOLD_BITS-1:0] turn_q, escape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_limit_q <= ECHO_BITS'(RstFrontLimit);
      side_limit_q  <= ECHO_BITS'(RstSideLimit);
      cruise_q      <= SpeedBits'(RstCruise);
      base_q        <= SpeedBits'(RstBase);
      gain_q        <= GainBits'(RstGain);
      diff_limit_q  <= SpeedBits'(RstDiffLimit);
      turn_q        <= HOLD_BITS'(RstTurn);
      escape_q      <= HOLD_BITS'(RstEscape);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRONT_LIMIT: front_limit_q <= cfg_data_i[ECHO_BITS-1:0];
        CFG_SIDE_LIMIT:  side_limit_q  <= cfg_data_i[ECHO_BITS-1:0];
        CFG_CRUISE:      cruise_q      <= cfg_data_i[SpeedBits-1:0];
        CFG_BASE:        base_q        <= cfg_data_i[SpeedBits-1:0];
        CFG_GAIN:        gain_q        <= cfg_data_i[GainBits-1:0];
        CFG_DIFF_LIMIT:  diff_limit_q  <= cfg_data_i[SpeedBits-1:0];
        CFG_TURN:        turn_q        <= cfg_data_i[HOLD_BITS-1:0];
        CFG_ESCAPE:      escape_q      <= cfg_data_i[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                 s1_valid_q;
  logic                 s1_func_q;
  logic [ECHO_BITS-1:0] s1_front_q, s1_left_q, s1_right_q;
  logic                 s1_adv;
  logic                 in_xfer;

  assign s1_adv    = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q  <= in_i.func;
      s1_front_q <= in_i.echo_front_us;
      s1_left_q  <= in_i.echo_left_us;
      s1_right_q <= in_i.echo_right_us;
    end
  end

  // Controller state.
  logic [2:0]                  act_q, act_d;
  logic [HOLD_BITS-1:0]        hold_q, hold_d;
  logic signed [DriveBits-1:0] left_q, left_d, right_q, right_d;
  logic                        acc_d;

  // Echo cleanup and proximity.
  logic [ECHO_BITS-1:0] ef, el, er;
  logic                 near_f, near_l, near_r, go_left;

  always_comb begin
    ef = (32'(s1_front_q) > 32'(EchoTimeoutUs)) ? '0 : s1_front_q;
    el = (32'(s1_left_q) > 32'(EchoTimeoutUs)) ? '0 : s1_left_q;
    er = (32'(s1_right_q) > 32'(EchoTimeoutUs)) ? '0 : s1_right_q;
    near_f = (ef != '0) && (ef <= front_limit_q);
    near_l = (el != '0) && (el <= side_limit_q);
    near_r = (er != '0) && (er <= side_limit_q);
    go_left = ((el != '0) && (er != '0)) ? (el > er) : (el == '0);
  end

  // Centering differential.
  logic                        c_neg;
  logic [ECHO_BITS-1:0]        c_mag;
  logic [ProdBits-1:0]         c_prod;
  logic [QBits-1:0]            c_q;
  logic [SpeedBits-1:0]        c_dmag;
  logic signed [SumBits-1:0]   c_base, c_diff, c_lsum, c_rsum;
  logic signed [DriveBits-1:0] c_left, c_right;

  always_comb begin
    c_neg  = er > el;
    c_mag  = c_neg ? (er - el) : (el - er);
    c_prod = ProdBits'(c_mag) * ProdBits'(gain_q);
    c_q    = c_prod[ProdBits-1:8];
    c_dmag = (c_q > QBits'(diff_limit_q)) ? diff_limit_q : c_q[SpeedBits-1:0];
    c_base = SumBits'(base_q);
    c_diff = SumBits'(c_dmag);
    c_lsum = c_neg ? (c_base - c_diff) : (c_base + c_diff);
    c_rsum = c_neg ? (c_base + c_diff) : (c_base - c_diff);
    c_left  = (c_lsum > $signed(SumBits'(FullDrive))) ? DriveBits'(FullDrive)
                                                      : c_lsum[DriveBits-1:0];
    c_right = (c_rsum > $signed(SumBits'(FullDrive))) ? DriveBits'(FullDrive)
                                                      : c_rsum[DriveBits-1:0];
    if ((el == '0) || (er == '0)) begin
      c_left  = DriveBits'(base_q);
      c_right = DriveBits'(base_q);
    end
  end

  // Next state.
  logic [HOLD_BITS-1:0] hold_dec;

  always_comb begin
    act_d    = act_q;
    hold_d   = hold_q;
    left_d   = left_q;
    right_d  = right_q;
    acc_d    = 1'b0;
    hold_dec = hold_q - 1'b1;
    if (s1_func_q) begin
      if (hold_q != '0) begin
        hold_d = hold_dec;
        if (hold_dec == '0) begin
          priority if (act_q == ACT_SPIN) begin
            act_d   = ACT_BRAKE;
            hold_d  = HOLD_BITS'(BrakeMs);
            left_d  = '0;
            right_d = '0;
          end else if (act_q == ACT_BRAKE) begin
            act_d   = ACT_READY;
            left_d  = '0;
            right_d = '0;
          end else begin
            act_d = ACT_READY;
          end
        end
      end
    end else if (hold_q == '0) begin
      acc_d = 1'b1;
      priority if (!near_f && !near_l && !near_r) begin
        act_d   = ACT_CRUISE;
        hold_d  = '0;
        left_d  = DriveBits'(cruise_q);
        right_d = DriveBits'(cruise_q);
      end else if (near_f) begin
        if (turn_q == '0) begin
          act_d   = ACT_BRAKE;
          hold_d  = HOLD_BITS'(BrakeMs);
          left_d  = '0;
          right_d = '0;
        end else begin
          act_d   = ACT_SPIN;
          hold_d  = turn_q;
          left_d  = go_left ? -DriveBits'(FullDrive) : DriveBits'(FullDrive);
          right_d = go_left ? DriveBits'(FullDrive) : -DriveBits'(FullDrive);
        end
      end else if (near_l) begin
        act_d   = ACT_ESCAPE;
        hold_d  = escape_q;
        left_d  = DriveBits'(FullDrive);
        right_d = -DriveBits'(EscapeInner);
      end else if (near_r) begin
        act_d   = ACT_ESCAPE;
        hold_d  = escape_q;
        left_d  = -DriveBits'(EscapeInner);
        right_d = DriveBits'(FullDrive);
      end else begin
        act_d   = ACT_CENTER;
        hold_d  = '0;
        left_d  = c_left;
        right_d = c_right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ACT_READY;
      hold_q  <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else if (s1_adv) begin
      act_q   <= act_d;
      hold_q  <= hold_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // Result register.
  logic                        out_valid_q;
  logic [SpeedBits-1:0]        lf_q, lr_q, rf_q, rr_q;
  logic [2:0]                  out_act_q;
  logic                        out_acc_q;
  logic signed [DriveBits-1:0] left_n, right_n;

  assign left_n  = -left_d;
  assign right_n = -right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lf_q      <= (left_d > 0) ? left_d[SpeedBits-1:0] : '0;
      lr_q      <= (left_d < 0) ? left_n[SpeedBits-1:0] : '0;
      rf_q      <= (right_d > 0) ? right_d[SpeedBits-1:0] : '0;
      rr_q      <= (right_d < 0) ? right_n[SpeedBits-1:0] : '0;
      out_act_q <= act_d;
      out_acc_q <= acc_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_fwd_duty  = lf_q;
  assign out_o.left_rev_duty  = lr_q;
  assign out_o.right_fwd_duty = rf_q;
  assign out_o.right_rev_duty = rr_q;
  assign out_o.action         = out_act_q;
  assign out_o.accepted       = out_acc_q;

  // A measurement that was acted upon never leaves the controller in the ready action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.accepted) |-> (out_o.action != ACT_READY))
    else $error("accepted measurement reported ready action");

  // Spin and brake always run with a hold timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((act_q == ACT_SPIN) || (act_q == ACT_BRAKE)) |-> (hold_q != '0))
    else $error("spin or brake without hold time");

  // Drives never go below negative full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q >= -$signed(DriveBits'(FullDrive))) && (right_q >= -$signed(DriveBits'(FullDrive))))
    else $error("drive below negative full scale");

  // A stalled result with a pending item blocks new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && s1_valid_q) |-> !in_i.ready)
    else $error("input taken while pipeline is full");

endmodule

`default_nettype wire
